[sv/ide_pkg.sv]
package ide_pkg;

    // Default sizing of the ring store.
    localparam int DEPTH_DEFAULT       = 16;
    localparam int HANDLE_BITS_DEFAULT = 32;

    // Fixed field widths of the request and response words.
    localparam int KIND_W   = 3;
    localparam int POS_W    = 4;
    localparam int HANDLE_W = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_BACK  = 3'd0,
        KIND_PUSH_FRONT = 3'd1,
        KIND_POP_BACK   = 3'd2,
        KIND_POP_FRONT  = 3'd3,
        KIND_READ       = 3'd4,
        KIND_REPLACE    = 3'd5,
        KIND_REMOVE     = 3'd6
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        kind_t               kind;
        logic [POS_W-1:0]    position;
        logic [HANDLE_W-1:0] handle_in;
    } req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle_out;
        status_t             status;
        logic [OCC_W-1:0]    occupancy;
    } rsp_t;

endpackage

[sv/ide_chan_if.sv]
interface ide_chan_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

[sv/ide_ram.sv]
module ide_ram #(
    parameter int WIDTH = ide_pkg::HANDLE_BITS_DEFAULT,
    parameter int DEPTH = ide_pkg::DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/ide_slot.sv]
module ide_slot #(
    parameter int DEPTH = ide_pkg::DEPTH_DEFAULT
) (
    input  logic [$clog2(DEPTH)-1:0] base,
    input  logic [$clog2(DEPTH)-1:0] offset,
    output logic [$clog2(DEPTH)-1:0] slot
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [PTR_W:0] sum;

    // Both operands are below DEPTH, so one conditional subtract wraps the ring.
    assign sum  = {1'b0, base} + {1'b0, offset};
    assign slot = (sum >= (PTR_W + 1)'(DEPTH)) ? PTR_W'(sum - (PTR_W + 1)'(DEPTH))
                                               : PTR_W'(sum);

endmodule

[sv/indexed_double_ended_queue.sv]
// Bounded double-ended queue of opaque handles with access by position.
// Requests arrive as words on the req channel (kind, position, handle_in)
// and each produces exactly one word on the rsp channel (handle_out, status,
// occupancy), in order. A word moves when valid and ready are both high.
// The block works on one request at a time: req.ready is high only while the
// sequencer is idle, and all entries live in a single-port-write RAM.
// A rejected or unused request passes through CALC and then FINISH; a push
// also passes through ACCESS, and pop, read and replace through ACCESS and
// FETCH. A remove adds SHIFT_CALC, SHIFT_READ and SHIFT_WRITE for every entry
// behind the gap, as each takes one read and one write of the RAM through the
// shared slot adder. The next request is taken in the cycle after the response
// has been loaded, so a request is not accepted before the last one is done.
// The response sits in an output register; a new request is accepted while it
// waits, and if the receiver stalls the sequencer holds the finished result
// until the register frees.
// Reset (rst_n low, asynchronous) empties the queue and drops any response
// not yet taken. The RAM contents are not cleared; only written entries are
// ever read back.
module indexed_double_ended_queue #(
    parameter int DEPTH       = ide_pkg::DEPTH_DEFAULT,
    parameter int HANDLE_BITS = ide_pkg::HANDLE_BITS_DEFAULT
) (
    input logic        clk,
    input logic        rst_n,
    ide_chan_if.sink   req,
    ide_chan_if.source rsp
);

    import ide_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [7:0] {
        S_IDLE        = 8'b0000_0001,
        S_CALC        = 8'b0000_0010,
        S_ACCESS      = 8'b0000_0100,
        S_FETCH       = 8'b0000_1000,
        S_SHIFT_CALC  = 8'b0001_0000,
        S_SHIFT_READ  = 8'b0010_0000,
        S_SHIFT_WRITE = 8'b0100_0000,
        S_FINISH      = 8'b1000_0000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    kind_t                kind_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [HANDLE_BITS-1:0] handle_reg;
    logic [PTR_W-1:0]     front_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [PTR_W-1:0]     slot_reg;
    logic [PTR_W-1:0]     src_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic [HANDLE_BITS-1:0] res_reg;
    status_t              status_reg;
    logic                 rsp_valid_reg;
    rsp_t                 rsp_payload_reg;

    logic                 req_fire;
    logic                 out_free;
    logic                 is_full;
    logic                 is_empty;
    logic                 pos_bad;
    logic                 calc_go;
    logic [PTR_W-1:0]     front_dec;
    logic [PTR_W-1:0]     front_inc;
    logic [PTR_W-1:0]     unit_offset;
    logic [PTR_W-1:0]     unit_slot;

    logic                 ram_we;
    logic [PTR_W-1:0]     ram_raddr;
    logic [HANDLE_BITS-1:0] ram_wdata;
    logic [HANDLE_BITS-1:0] ram_rdata;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_payload_reg;

    // Checks against the count as it stood when the request was taken.
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign pos_bad  = (CMP_W'(pos_reg) >= CMP_W'(count_reg));

    assign front_dec = (front_reg == '0) ? PTR_W'(DEPTH - 1) : PTR_W'(front_reg - 1'b1);
    assign front_inc = (front_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(front_reg + 1'b1);

    always_comb
    begin
        unique case (kind_reg)
            KIND_PUSH_BACK:  calc_go = !is_full;
            KIND_PUSH_FRONT: calc_go = !is_full;
            KIND_POP_BACK:   calc_go = !is_empty;
            KIND_POP_FRONT:  calc_go = !is_empty;
            KIND_READ:       calc_go = !pos_bad;
            KIND_REPLACE:    calc_go = !pos_bad;
            KIND_REMOVE:     calc_go = !pos_bad;
            default:         calc_go = 1'b0;
        endcase
    end

    // Offset fed to the shared slot adder: the position of the entry to touch.
    always_comb
    begin
        if (state_reg == S_SHIFT_CALC)
        begin
            unit_offset = PTR_W'(idx_reg + 1'b1);
        end
        else
        begin
            unique case (kind_reg)
                KIND_PUSH_BACK: unit_offset = PTR_W'(count_reg);
                KIND_POP_BACK:  unit_offset = PTR_W'(count_reg - 1'b1);
                KIND_READ,
                KIND_REPLACE,
                KIND_REMOVE:    unit_offset = PTR_W'(pos_reg);
                default:        unit_offset = '0;
            endcase
        end
    end

    ide_slot #(
        .DEPTH (DEPTH)
    ) u_slot (
        .base   (front_reg),
        .offset (unit_offset),
        .slot   (unit_slot)
    );

    // RAM port control: pushes write in ACCESS, replace writes once the old
    // handle has been fetched, and each shift step writes the moved entry.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = handle_reg;
        ram_raddr = slot_reg;
        unique case (state_reg)
            S_ACCESS:
            begin
                ram_we = (kind_reg == KIND_PUSH_BACK) || (kind_reg == KIND_PUSH_FRONT);
            end
            S_FETCH:
            begin
                ram_we = (kind_reg == KIND_REPLACE);
            end
            S_SHIFT_READ:
            begin
                ram_raddr = src_reg;
            end
            S_SHIFT_WRITE:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    ide_ram #(
        .WIDTH (HANDLE_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (slot_reg),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                state_next = calc_go ? S_ACCESS : S_FINISH;
            end
            S_ACCESS:
            begin
                if ((kind_reg == KIND_PUSH_BACK) || (kind_reg == KIND_PUSH_FRONT))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                // The count has already dropped, so entries remain behind the
                // gap while the index is below it.
                if ((kind_reg == KIND_REMOVE) && (idx_reg < count_reg))
                begin
                    state_next = S_SHIFT_CALC;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT_CALC:
            begin
                state_next = S_SHIFT_READ;
            end
            S_SHIFT_READ:
            begin
                state_next = S_SHIFT_WRITE;
            end
            S_SHIFT_WRITE:
            begin
                if (CNT_W'(idx_reg + 1'b1) < count_reg)
                begin
                    state_next = S_SHIFT_CALC;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if ((state_reg == S_CALC) && calc_go)
            begin
                unique case (kind_reg)
                    KIND_PUSH_BACK:
                    begin
                        count_reg <= CNT_W'(count_reg + 1'b1);
                    end
                    KIND_PUSH_FRONT:
                    begin
                        front_reg <= front_dec;
                        count_reg <= CNT_W'(count_reg + 1'b1);
                    end
                    KIND_POP_BACK,
                    KIND_REMOVE:
                    begin
                        count_reg <= CNT_W'(count_reg - 1'b1);
                    end
                    KIND_POP_FRONT:
                    begin
                        front_reg <= front_inc;
                        count_reg <= CNT_W'(count_reg - 1'b1);
                    end
                    default:
                    begin
                        count_reg <= count_reg;
                    end
                endcase
            end

            if ((state_reg == S_FINISH) && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            kind_reg   <= kind_t'(req.payload.kind);
            pos_reg    <= req.payload.position;
            handle_reg <= HANDLE_BITS'(req.payload.handle_in);
        end

        unique case (state_reg)
            S_CALC:
            begin
                res_reg    <= '0;
                status_reg <= STATUS_OK;
                idx_reg    <= CNT_W'(pos_reg);
                slot_reg   <= unit_slot;
                unique case (kind_reg)
                    KIND_PUSH_BACK:
                    begin
                        if (is_full)
                        begin
                            status_reg <= STATUS_FULL;
                        end
                    end
                    KIND_PUSH_FRONT:
                    begin
                        slot_reg <= front_dec;
                        if (is_full)
                        begin
                            status_reg <= STATUS_FULL;
                        end
                    end
                    KIND_POP_BACK:
                    begin
                        if (is_empty)
                        begin
                            status_reg <= STATUS_EMPTY;
                        end
                    end
                    KIND_POP_FRONT:
                    begin
                        slot_reg <= front_reg;
                        if (is_empty)
                        begin
                            status_reg <= STATUS_EMPTY;
                        end
                    end
                    KIND_READ,
                    KIND_REPLACE,
                    KIND_REMOVE:
                    begin
                        if (pos_bad)
                        begin
                            status_reg <= STATUS_EMPTY;
                        end
                    end
                    default:
                    begin
                        status_reg <= STATUS_OK;
                    end
                endcase
            end
            S_FETCH:
            begin
                res_reg <= ram_rdata;
            end
            S_SHIFT_CALC:
            begin
                src_reg <= unit_slot;
            end
            S_SHIFT_WRITE:
            begin
                slot_reg <= src_reg;
                idx_reg  <= CNT_W'(idx_reg + 1'b1);
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    rsp_payload_reg.handle_out <= HANDLE_W'(res_reg);
                    rsp_payload_reg.status     <= status_reg;
                    rsp_payload_reg.occupancy  <= OCC_W'(count_reg);
                end
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

    // The count never exceeds the ring size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above ring depth");

    // The count is only updated when a request is evaluated.
    a_count_only_calc: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_CALC |=> $stable(count_reg))
        else $error("entry count changed outside evaluation");

    // Any change of the count is a single step.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        $stable(count_reg) || (count_reg == CNT_W'($past(count_reg) + 1'b1))
        || (count_reg == CNT_W'($past(count_reg) - 1'b1)))
        else $error("entry count moved by more than one");

    // The gap-closing walk stays within the held entries.
    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHIFT_CALC |-> idx_reg < count_reg)
        else $error("remove shift index beyond the held entries");

    // Only pushes can report a full queue.
    a_full_on_push: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) && (status_reg == STATUS_FULL)
        |-> (kind_reg == KIND_PUSH_BACK) || (kind_reg == KIND_PUSH_FRONT))
        else $error("full status on a request that is not a push");

endmodule
